// ===== hdl/lrsv_pkg.sv =====
// ----------------------------------------------------------------------------
// lrsv_pkg
// Shared types and constants of the launch record stream validator.
// ----------------------------------------------------------------------------
package lrsv_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int SIZE_W      = 21;
    localparam int COUNT_W     = 13;
    localparam int LEFT_W      = 14;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 21;

    localparam logic [SIZE_W-1:0]  HDR_BYTES        = 21'd24;
    localparam logic [SIZE_W-1:0]  MAX_RECORD_BYTES = 21'd1048576;
    localparam logic [SIZE_W-1:0]  LEN_SAT          = 21'h1FFFFF;
    localparam logic [SIZE_W-1:0]  LEN_PREFIX_BYTES = 21'd4;
    localparam logic [COUNT_W-1:0] MAX_LIST_ENTRIES = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_SAT        = 13'h1FFF;
    localparam logic [WORD_W-1:0]  MAGIC_WORD       = 32'h41584c44;
    localparam logic [WORD_W-1:0]  VERSION_WORD     = 32'd1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BYTES       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ARGUMENTS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ENVIRONMENT = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LIMITS   = 2'd1,
        ST_EXCEEDED = 2'd2,
        ST_FRAMING  = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] argument_count;
        logic [COUNT_W-1:0] environment_count;
    } t_out_beat;

    // Limits as seen by the parser, with their validity already decided.
    typedef struct packed {
        logic [SIZE_W-1:0]  max_bytes;
        logic [COUNT_W-1:0] max_arguments;
        logic [COUNT_W-1:0] max_environment;
        logic               valid;
    } t_limits;

endpackage

// ===== hdl/lrsv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lrsv_cfg_regs
// Limit registers written through the configuration channel, plus the check
// that the programmed limits form a usable set.
// ----------------------------------------------------------------------------
module lrsv_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lrsv_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [lrsv_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output lrsv_pkg::t_limits                  o_limits
);

    logic [lrsv_pkg::SIZE_W-1:0]  r_max_bytes;
    logic [lrsv_pkg::COUNT_W-1:0] r_max_arguments;
    logic [lrsv_pkg::COUNT_W-1:0] r_max_environment;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes       <= lrsv_pkg::MAX_RECORD_BYTES;
            r_max_arguments   <= lrsv_pkg::MAX_LIST_ENTRIES;
            r_max_environment <= lrsv_pkg::MAX_LIST_ENTRIES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lrsv_pkg::CFG_MAX_BYTES: begin
                    r_max_bytes <= i_cfg_data[lrsv_pkg::SIZE_W-1:0];
                end
                lrsv_pkg::CFG_MAX_ARGUMENTS: begin
                    r_max_arguments <= i_cfg_data[lrsv_pkg::COUNT_W-1:0];
                end
                lrsv_pkg::CFG_MAX_ENVIRONMENT: begin
                    r_max_environment <= i_cfg_data[lrsv_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_limits.max_bytes       = r_max_bytes;
        o_limits.max_arguments   = r_max_arguments;
        o_limits.max_environment = r_max_environment;
        o_limits.valid = (r_max_bytes >= lrsv_pkg::HDR_BYTES) &&
                         (r_max_bytes <= lrsv_pkg::MAX_RECORD_BYTES) &&
                         (r_max_arguments != '0) &&
                         (r_max_arguments <= lrsv_pkg::MAX_LIST_ENTRIES) &&
                         (r_max_environment <= lrsv_pkg::MAX_LIST_ENTRIES);
    end

endmodule

// ===== hdl/lrsv_in_stage.sv =====
// ----------------------------------------------------------------------------
// lrsv_in_stage
// Input register that holds one record byte until the parser takes it.
// ----------------------------------------------------------------------------
module lrsv_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lrsv_pkg::t_in_beat i_in_beat,
    output logic               o_beat_valid,
    output lrsv_pkg::t_in_beat o_beat,
    input  logic               i_advance
);

    logic               r_valid;
    lrsv_pkg::t_in_beat r_beat;
    logic               accept;

    // The slot is free when empty or when its beat moves on this cycle.
    assign o_in_ready   = !r_valid || i_advance;
    assign accept       = i_in_valid && o_in_ready;
    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= i_in_beat;
        end
    end

endmodule

// ===== hdl/lrsv_parser.sv =====
// ----------------------------------------------------------------------------
// lrsv_parser
// Record parser: tracks header and string framing one byte per cycle and loads
// the status beat on the last byte into the result register, once it has room.
// ----------------------------------------------------------------------------
module lrsv_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrsv_pkg::t_limits   i_limits,
    input  logic                i_beat_valid,
    input  lrsv_pkg::t_in_beat  i_beat,
    output logic                o_advance,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lrsv_pkg::t_out_beat o_out_beat
);

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_LENGTH = 5'b00010,
        PH_BODY   = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_SKIP   = 5'b10000
    } t_phase;

    localparam logic [2:0] HW_MAGIC    = 3'd0;
    localparam logic [2:0] HW_VERSION  = 3'd1;
    localparam logic [2:0] HW_SIZE     = 3'd2;
    localparam logic [2:0] HW_ARGS     = 3'd3;
    localparam logic [2:0] HW_ENV      = 3'd4;
    localparam logic [2:0] HW_RESERVED = 3'd5;

    function automatic logic [lrsv_pkg::COUNT_W-1:0] sat_count(
        input logic [lrsv_pkg::WORD_W-1:0] v
    );
        return (|v[lrsv_pkg::WORD_W-1:lrsv_pkg::COUNT_W]) ? lrsv_pkg::COUNT_SAT
                                                          : v[lrsv_pkg::COUNT_W-1:0];
    endfunction

    logic [lrsv_pkg::SIZE_W-1:0]  r_byte_count,   n_byte_count;
    t_phase                       r_phase,        n_phase;
    logic [lrsv_pkg::WORD_W-1:0]  r_word_shift,   n_word_shift;
    logic [lrsv_pkg::WORD_W-1:0]  r_declared_size, n_declared_size;
    logic [lrsv_pkg::COUNT_W-1:0] r_arg_total,    n_arg_total;
    logic [lrsv_pkg::COUNT_W-1:0] r_env_total,    n_env_total;
    logic [lrsv_pkg::LEFT_W-1:0]  r_strings_left, n_strings_left;
    logic [lrsv_pkg::SIZE_W-1:0]  r_str_bytes,    n_str_bytes;
    logic                         r_hdr_err,      n_hdr_err;
    logic                         r_cnt_err,      n_cnt_err;
    logic                         r_str_err,      n_str_err;
    logic                         r_out_valid;
    lrsv_pkg::t_out_beat          r_out_beat,     n_out_beat;

    logic                         fire;
    logic [lrsv_pkg::BYTE_W-1:0]  b;
    logic [lrsv_pkg::WORD_W-1:0]  w;
    logic                         hdr_word_end;
    logic [2:0]                   word_sel;
    logic                         hdr_err_rsv;
    logic                         cnt_err_hdr;
    logic [lrsv_pkg::LEFT_W-1:0]  list_total;
    logic [lrsv_pkg::SIZE_W-1:0]  str_bytes_dec;
    logic [lrsv_pkg::LEFT_W-1:0]  strings_dec;
    logic                         name_string;
    logic                         oversize;
    logic                         hdr_final;
    logic                         str_final;
    lrsv_pkg::t_status            status;

    // A plain byte always moves on; a last byte needs room in the result register.
    assign o_advance = i_beat_valid &&
                       (!i_beat.last_byte || !r_out_valid || i_out_ready);
    assign fire      = o_advance;

    assign b            = i_beat.byte_value;
    assign w            = {b, r_word_shift[lrsv_pkg::WORD_W-1:lrsv_pkg::BYTE_W]};
    assign hdr_word_end = (r_byte_count < lrsv_pkg::HDR_BYTES) && (r_byte_count[1:0] == 2'd3);
    assign word_sel     = r_byte_count[4:2];
    assign hdr_err_rsv  = r_hdr_err || (w != '0);
    assign cnt_err_hdr  = (r_arg_total > i_limits.max_arguments) ||
                          (r_env_total > i_limits.max_environment) ||
                          (r_arg_total > lrsv_pkg::MAX_LIST_ENTRIES) ||
                          (r_env_total > lrsv_pkg::MAX_LIST_ENTRIES);
    assign list_total    = {1'b0, r_arg_total} + {1'b0, r_env_total};
    assign str_bytes_dec = r_str_bytes - 1'b1;
    assign strings_dec   = r_strings_left - 1'b1;
    // The executable and the directory are the two strings ahead of the lists.
    assign name_string   = r_strings_left > list_total;

    always_comb begin
        n_byte_count    = (r_byte_count != lrsv_pkg::LEN_SAT) ? r_byte_count + 1'b1
                                                              : r_byte_count;
        n_phase         = r_phase;
        n_word_shift    = w;
        n_declared_size = r_declared_size;
        n_arg_total     = r_arg_total;
        n_env_total     = r_env_total;
        n_strings_left  = r_strings_left;
        n_str_bytes     = r_str_bytes;
        n_hdr_err       = r_hdr_err;
        n_cnt_err       = r_cnt_err;
        n_str_err       = r_str_err;

        unique case (r_phase)
            PH_HEADER: begin
                if (hdr_word_end) begin
                    unique case (word_sel)
                        HW_MAGIC: begin
                            if (w != lrsv_pkg::MAGIC_WORD) n_hdr_err = 1'b1;
                        end
                        HW_VERSION: begin
                            if (w != lrsv_pkg::VERSION_WORD) n_hdr_err = 1'b1;
                        end
                        HW_SIZE: begin
                            n_declared_size = w;
                        end
                        HW_ARGS: begin
                            n_arg_total = sat_count(w);
                            if (w == '0) n_hdr_err = 1'b1;
                        end
                        HW_ENV: begin
                            n_env_total = sat_count(w);
                        end
                        HW_RESERVED: begin
                            n_hdr_err = hdr_err_rsv;
                            n_cnt_err = cnt_err_hdr;
                            if (hdr_err_rsv || cnt_err_hdr) begin
                                n_phase = PH_SKIP;
                            end else begin
                                n_strings_left = lrsv_pkg::LEFT_W'(2) + list_total;
                                n_phase        = PH_LENGTH;
                                n_str_bytes    = lrsv_pkg::LEN_PREFIX_BYTES;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            PH_LENGTH: begin
                n_str_bytes = str_bytes_dec;
                if (str_bytes_dec == '0) begin
                    priority if ((w == '0 && name_string) ||
                                 (|w[lrsv_pkg::WORD_W-1:lrsv_pkg::SIZE_W])) begin
                        n_str_err = 1'b1;
                        n_phase   = PH_SKIP;
                    end else if (w == '0) begin
                        n_strings_left = strings_dec;
                        if (strings_dec == '0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase     = PH_LENGTH;
                            n_str_bytes = lrsv_pkg::LEN_PREFIX_BYTES;
                        end
                    end else begin
                        n_phase     = PH_BODY;
                        n_str_bytes = w[lrsv_pkg::SIZE_W-1:0];
                    end
                end
            end
            PH_BODY: begin
                if (b == '0) begin
                    n_str_err = 1'b1;
                    n_phase   = PH_SKIP;
                end else begin
                    n_str_bytes = str_bytes_dec;
                    if (str_bytes_dec == '0) begin
                        n_strings_left = strings_dec;
                        if (strings_dec == '0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase     = PH_LENGTH;
                            n_str_bytes = lrsv_pkg::LEN_PREFIX_BYTES;
                        end
                    end
                end
            end
            PH_DONE: begin
                // Any byte after the last string breaks the framing.
                n_str_err = 1'b1;
                n_phase   = PH_SKIP;
            end
            PH_SKIP: begin
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase

        // Final checks use the state as it stands after this byte.
        oversize  = n_byte_count > i_limits.max_bytes;
        hdr_final = n_hdr_err || (n_phase == PH_HEADER) ||
                    (n_declared_size != {{(lrsv_pkg::WORD_W-lrsv_pkg::SIZE_W){1'b0}},
                                         n_byte_count});
        str_final = n_str_err || !((n_phase == PH_DONE) || (n_phase == PH_SKIP));

        priority if (!i_limits.valid) begin
            status = lrsv_pkg::ST_LIMITS;
        end else if (oversize) begin
            status = lrsv_pkg::ST_EXCEEDED;
        end else if (hdr_final) begin
            status = lrsv_pkg::ST_FRAMING;
        end else if (n_cnt_err) begin
            status = lrsv_pkg::ST_EXCEEDED;
        end else if (str_final) begin
            status = lrsv_pkg::ST_FRAMING;
        end else begin
            status = lrsv_pkg::ST_OK;
        end

        n_out_beat.status            = status;
        n_out_beat.argument_count    = (status == lrsv_pkg::ST_OK) ? n_arg_total : '0;
        n_out_beat.environment_count = (status == lrsv_pkg::ST_OK) ? n_env_total : '0;

        // The last byte closes the record and the parser starts over.
        if (i_beat.last_byte) begin
            n_byte_count    = '0;
            n_phase         = PH_HEADER;
            n_word_shift    = '0;
            n_declared_size = '0;
            n_arg_total     = '0;
            n_env_total     = '0;
            n_strings_left  = '0;
            n_str_bytes     = '0;
            n_hdr_err       = 1'b0;
            n_cnt_err       = 1'b0;
            n_str_err       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_phase         <= PH_HEADER;
            r_word_shift    <= '0;
            r_declared_size <= '0;
            r_arg_total     <= '0;
            r_env_total     <= '0;
            r_strings_left  <= '0;
            r_str_bytes     <= '0;
            r_hdr_err       <= 1'b0;
            r_cnt_err       <= 1'b0;
            r_str_err       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (fire) begin
                r_byte_count    <= n_byte_count;
                r_phase         <= n_phase;
                r_word_shift    <= n_word_shift;
                r_declared_size <= n_declared_size;
                r_arg_total     <= n_arg_total;
                r_env_total     <= n_env_total;
                r_strings_left  <= n_strings_left;
                r_str_bytes     <= n_str_bytes;
                r_hdr_err       <= n_hdr_err;
                r_cnt_err       <= n_cnt_err;
                r_str_err       <= n_str_err;
            end
            if (fire && i_beat.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_beat.last_byte) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_beat.last_byte) |=> (r_byte_count == '0 && r_phase == PH_HEADER))
        else $error("parser state not cleared after the last byte");

    a_strings_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LENGTH || r_phase == PH_BODY) |->
        (r_strings_left != '0 && r_str_bytes != '0))
        else $error("string phase entered with nothing left to read");

    a_ok_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat.status == lrsv_pkg::ST_OK) |->
        (r_out_beat.argument_count != '0 &&
         r_out_beat.argument_count <= lrsv_pkg::MAX_LIST_ENTRIES &&
         r_out_beat.environment_count <= lrsv_pkg::MAX_LIST_ENTRIES))
        else $error("ok status with counts out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_beat))
        else $error("pending result overwritten");

endmodule

// ===== hdl/launch_record_stream_validator.sv =====
// ----------------------------------------------------------------------------
// launch_record_stream_validator
// Checks a byte-serial launch record against its header and string layout.
// ----------------------------------------------------------------------------
// The block takes one record byte per beat, one beat every clock cycle,
// stalling only when a last byte finds the result register still full.
// Each byte passes an input register and then the parser's counter and
// compare logic. Bytes other than the last produce no result. The last byte
// of a record yields one result beat (status, argument count, environment
// count), loaded into the result register when the parser takes that byte;
// it is held until taken, and the block keeps accepting the next record's
// bytes meanwhile. The user must write limits through the configuration
// channel only while no record is in progress; the block does not enforce it.
module launch_record_stream_validator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  lrsv_pkg::t_in_beat                 i_in_beat,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output lrsv_pkg::t_out_beat                o_out_beat,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lrsv_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [lrsv_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lrsv_pkg::t_limits  limits;
    logic               beat_valid;
    lrsv_pkg::t_in_beat beat;
    logic               advance;

    lrsv_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limits    (limits)
    );

    lrsv_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_beat    (i_in_beat),
        .o_beat_valid (beat_valid),
        .o_beat       (beat),
        .i_advance    (advance)
    );

    lrsv_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_limits     (limits),
        .i_beat_valid (beat_valid),
        .i_beat       (beat),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_beat   (o_out_beat)
    );

endmodule
